>>> design/rc_servo_frame_parser_core_assert.svh
// ----------------------------------------------------------------------------
// rc_servo_frame_parser_core_assert.svh
// Assertion macros shared by the frame parser modules.
// ----------------------------------------------------------------------------
`ifndef RC_SERVO_FRAME_PARSER_CORE_ASSERT_SVH
`define RC_SERVO_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCSFP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCSFP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsfp: next-cycle check failed");

`endif

>>> design/rcsfp_pkg.sv
// ----------------------------------------------------------------------------
// rcsfp_pkg
// Types and constants shared by the RC servo frame parser modules.
// ----------------------------------------------------------------------------
package rcsfp_pkg;

    // Frame geometry.
    localparam int CHANNELS    = 14;
    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int CSUM_SPAN   = 30;
    localparam int CSUM_W      = 16;
    localparam logic [CSUM_W-1:0] CSUM_SEED = 16'hFFFF;
    localparam int CH_W        = 4;

    // Two frame banks in the store.
    localparam int BANKS       = 2;
    localparam int MEM_AW      = POS_W + 1;
    localparam int MEM_DEPTH   = BANKS * FRAME_BYTES;

    // Bank queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = 2;

    // Idle counter.
    localparam logic [7:0] IDLE_MAX = 8'hFF;

    // Input command codes.
    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_LEN = 2'd0,
        REG_CMD = 2'd1,
        REG_GAP = 2'd2
    } t_reg_idx;

    // Configuration seen by the front part.
    typedef struct packed {
        logic [7:0] hdr_len;
        logic [7:0] hdr_cmd;
        logic [7:0] gap_ms;
    } t_cfg;

    // Write request into the frame store.
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // Back part hands a bank back to the front part.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD_LO,
        BK_RD_HI,
        BK_EMIT
    } t_back_state;

endpackage

>>> design/rcsfp_frame_store.sv
// ----------------------------------------------------------------------------
// rcsfp_frame_store
// Two-bank byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcsfp_frame_store (
    input  logic                      i_clk,
    input  rcsfp_pkg::t_mem_wr        i_wr,
    input  logic [rcsfp_pkg::MEM_AW-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);
    import rcsfp_pkg::*;

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/rcsfp_front.sv
// ----------------------------------------------------------------------------
// rcsfp_front
// Accepts bytes and ticks, tracks idle time and frame position, checks the
// header and the checksum, fills the frame store and queues good frames.
// ----------------------------------------------------------------------------
`include "rc_servo_frame_parser_core_assert.svh"

module rcsfp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcsfp_pkg::t_cfg     i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [7:0]          i_rx_byte,
    output rcsfp_pkg::t_mem_wr  o_wr,
    output logic                o_push,
    output logic                o_push_bank,
    input  rcsfp_pkg::t_done    i_done
);
    import rcsfp_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_idle, n_idle;
    logic [CSUM_W-1:0] r_sum, n_sum;
    logic [7:0]        r_csum_lo, n_csum_lo;
    logic              r_wbank, n_wbank;
    logic [BANKS-1:0]  r_busy, n_busy;

    logic              acc;
    logic              is_byte;
    logic              is_tick;
    logic              gap;
    logic [POS_W-1:0]  eff_pos;
    logic              hdr_bad;
    logic              store;
    logic              frame_end;
    logic              good;

    // Requests are taken while the bank being filled is free.
    assign o_in_ready = !r_busy[r_wbank];
    assign acc        = i_in_valid && o_in_ready;
    assign is_byte    = acc && (i_command == CMD_BYTE);
    assign is_tick    = acc && (i_command == CMD_TICK);

    // A long idle gap restarts the frame before the byte is examined.
    assign gap     = r_idle > i_cfg.gap_ms;
    assign eff_pos = gap ? '0 : r_pos;

    // Header checks on the first two positions.
    assign hdr_bad = ((eff_pos == POS_W'(0)) && (i_rx_byte != i_cfg.hdr_len)) ||
                     ((eff_pos == POS_W'(1)) && (i_rx_byte != i_cfg.hdr_cmd));
    assign store     = is_byte && !hdr_bad;
    assign frame_end = store && (eff_pos == POS_W'(FRAME_BYTES - 1));
    assign good      = frame_end && ({i_rx_byte, r_csum_lo} == r_sum);

    assign o_wr.en     = store;
    assign o_wr.addr   = {r_wbank, eff_pos};
    assign o_wr.data   = i_rx_byte;
    assign o_push      = good;
    assign o_push_bank = r_wbank;

    // Next-state logic for position, idle time, checksum and banks.
    always_comb begin
        n_pos     = r_pos;
        n_idle    = r_idle;
        n_sum     = r_sum;
        n_csum_lo = r_csum_lo;
        n_wbank   = r_wbank;
        n_busy    = r_busy;

        if (is_tick && (r_idle != IDLE_MAX)) begin
            n_idle = r_idle + 8'd1;
        end

        if (is_byte) begin
            n_idle = '0;
            n_pos  = hdr_bad ? '0 : eff_pos + POS_W'(1);
        end

        // Running checksum over the leading bytes.
        if (store) begin
            if (eff_pos == POS_W'(0)) begin
                n_sum = CSUM_SEED - {8'd0, i_rx_byte};
            end else if (eff_pos < POS_W'(CSUM_SPAN)) begin
                n_sum = r_sum - {8'd0, i_rx_byte};
            end
            if (eff_pos == POS_W'(CSUM_SPAN)) begin
                n_csum_lo = i_rx_byte;
            end
        end

        // Bank ownership: the back part releases, a good frame claims.
        if (i_done.valid) begin
            n_busy[i_done.bank] = 1'b0;
        end
        if (good) begin
            n_busy[r_wbank] = 1'b1;
            n_wbank         = !r_wbank;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_idle  <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_idle  <= n_idle;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

    // Checksum registers.
    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_csum_lo <= n_csum_lo;
    end

    `RCSFP_ASSERT_NEXT(a_tick_counts, i_clk, i_rst_n, is_tick && (r_idle != IDLE_MAX), r_idle == $past(r_idle) + 8'd1)
    `RCSFP_ASSERT_NEXT(a_gap_restart, i_clk, i_rst_n, is_byte && gap, r_pos <= POS_W'(1))
    `RCSFP_ASSERT_NEXT(a_push_claims, i_clk, i_rst_n, o_push, r_busy[$past(r_wbank)] && (r_wbank != $past(r_wbank)))

endmodule

>>> design/rcsfp_frame_queue.sv
// ----------------------------------------------------------------------------
// rcsfp_frame_queue
// Short queue of completed frame banks between the front and back parts.
// ----------------------------------------------------------------------------
`include "rc_servo_frame_parser_core_assert.svh"

module rcsfp_frame_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_push_bank,
    input  logic i_pop,
    output logic o_valid,
    output logic o_bank
);
    import rcsfp_pkg::*;

    logic [QUEUE_DEPTH-1:0] r_slot;
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [QCNT_W-1:0]      r_count;

    assign o_valid = (r_count != '0);
    assign o_bank  = r_slot[r_rd_ptr];

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_bank;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `RCSFP_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, r_count != QCNT_W'(QUEUE_DEPTH))
    `RCSFP_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

>>> design/rcsfp_back.sv
// ----------------------------------------------------------------------------
// rcsfp_back
// Reads a queued frame bank two bytes per channel and emits the channel
// values through a registered output stage.
// ----------------------------------------------------------------------------
module rcsfp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic                         i_q_bank,
    output logic                         o_pop,
    output logic [rcsfp_pkg::MEM_AW-1:0] o_rd_addr,
    input  logic [7:0]                   i_rd_data,
    output rcsfp_pkg::t_done             o_done,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rcsfp_pkg::CH_W-1:0]   o_channel_index,
    output logic [15:0]                  o_channel_value,
    output logic                         o_last_channel
);
    import rcsfp_pkg::*;

    t_back_state      r_state, n_state;
    logic             r_bank, n_bank;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [7:0]       r_lo;
    logic             r_o_valid;
    logic [CH_W-1:0]  r_o_idx;
    logic [15:0]      r_o_val;
    logic             r_o_last;

    logic [POS_W-1:0] lo_pos;
    logic [POS_W-1:0] hi_pos;
    logic             last;
    logic             out_free;
    logic             load_lo;
    logic             load_out;

    // Channel k sits at bytes 2+2k (low) and 3+2k (high).
    assign lo_pos   = {r_ch, 1'b0} + POS_W'(2);
    assign hi_pos   = {lo_pos[POS_W-1:1], 1'b1};
    assign last     = (r_ch == CH_W'(CHANNELS - 1));
    assign out_free = !r_o_valid || i_out_ready;

    // Sequencer: next state and control outputs.
    always_comb begin
        n_state      = r_state;
        n_bank       = r_bank;
        n_ch         = r_ch;
        o_pop        = 1'b0;
        o_rd_addr    = {r_bank, hi_pos};
        o_done.valid = 1'b0;
        o_done.bank  = r_bank;
        load_lo      = 1'b0;
        load_out     = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_bank  = i_q_bank;
                    n_ch    = '0;
                    n_state = BK_RD_LO;
                end
            end
            BK_RD_LO: begin
                o_rd_addr = {r_bank, lo_pos};
                n_state   = BK_RD_HI;
            end
            BK_RD_HI: begin
                load_lo = 1'b1;
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (last) begin
                        o_done.valid = 1'b1;
                        n_state      = BK_IDLE;
                    end else begin
                        n_ch    = r_ch + CH_W'(1);
                        n_state = BK_RD_LO;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bank <= n_bank;
        r_ch   <= n_ch;
        if (load_lo) begin
            r_lo <= i_rd_data;
        end
        if (load_out) begin
            r_o_idx  <= r_ch;
            r_o_val  <= {i_rd_data, r_lo};
            r_o_last <= last;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_channel_index = r_o_idx;
    assign o_channel_value = r_o_val;
    assign o_last_channel  = r_o_last;

endmodule

>>> design/rc_servo_frame_parser_core.sv
// ----------------------------------------------------------------------------
// rc_servo_frame_parser_core
// 14-channel RC receiver frame parser with an APB register port.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): each request carries i_command
// (a serial byte or a one millisecond tick) and i_rx_byte. One request is
// taken per cycle while the frame bank being filled is free; the front part
// stalls only when both store banks still hold frames waiting to be emitted.
// Output channel (o_out_valid / i_out_ready): a good 32-byte frame yields
// 14 requests, channel 0 to 13, the last one flagged by o_last_channel.
// The back sequencer pops the bank and per channel reads the low, then high
// byte through the single store read port, then emits the channel. A stalled
// receiver holds the output register and the back sequencer; the front part
// keeps taking bytes into the other bank. Registers: 0x0 header length byte,
// 0x4 header command byte, 0x8 gap timeout in milliseconds; the user must
// write them only while the block is idle, which the block does not enforce.
// Reset (i_rst_n low, synchronous) restores the register defaults, clears
// the frame position, idle counter, bank queue and output valid. The frame
// store needs no clearing, since a frame is only read once fully written.
// ----------------------------------------------------------------------------
module rc_servo_frame_parser_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [7:0]                 i_rx_byte,
    // Output channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [rcsfp_pkg::CH_W-1:0] o_channel_index,
    output logic [15:0]                o_channel_value,
    output logic                       o_last_channel
);
    import rcsfp_pkg::*;

    t_cfg              r_cfg;
    t_mem_wr           mem_wr;
    logic [MEM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              push;
    logic              push_bank;
    logic              pop;
    logic              q_valid;
    logic              q_bank;
    t_done             done;
    logic              cfg_wr;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_len <= 8'd32;
            r_cfg.hdr_cmd <= 8'd64;
            r_cfg.gap_ms  <= 8'd10;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LEN: r_cfg.hdr_len <= pwdata[7:0];
                REG_CMD: r_cfg.hdr_cmd <= pwdata[7:0];
                REG_GAP: r_cfg.gap_ms  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_LEN: prdata = {24'd0, r_cfg.hdr_len};
            REG_CMD: prdata = {24'd0, r_cfg.hdr_cmd};
            REG_GAP: prdata = {24'd0, r_cfg.gap_ms};
            default: prdata = '0;
        endcase
    end

    // Front part: framing, header and checksum checks.
    rcsfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_rx_byte   (i_rx_byte),
        .o_wr        (mem_wr),
        .o_push      (push),
        .o_push_bank (push_bank),
        .i_done      (done)
    );

    // Two-bank frame store.
    rcsfp_frame_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Queue of good frames.
    rcsfp_frame_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_bank (push_bank),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_bank      (q_bank)
    );

    // Back part: channel emission.
    rcsfp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_bank        (q_bank),
        .o_pop           (pop),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_done          (done),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

>>> tb/rc_servo_frame_parser_core_tb.sv
// ----------------------------------------------------------------------------
// rc_servo_frame_parser_core_tb
// Self-checking bench for the RC servo frame parser. Serial bytes and
// millisecond ticks are offered on the input channel, and each request is
// run through a behavioural copy of the parser as it is taken. Channel
// results are checked in order against that copy, while both sides idle at
// random. A final stretch without idling moves the header registers to their
// extremes and the gap timeout to its top value.
// ----------------------------------------------------------------------------
module rc_servo_frame_parser_core_tb;

    import rcsfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 700;
    localparam int SAT_TICKS    = 256;

    // One request on the input channel.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } link_event_t;

    // One channel value that the parser should emit.
    typedef struct packed {
        logic [CH_W-1:0] index;
        logic [15:0]     value;
        logic            last;
    } channel_word_t;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [3:0]        paddr           = '0;
    logic [31:0]       pwdata          = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid      = 1'b0;
    logic              o_in_ready;
    logic              i_command       = 1'b0;
    logic [7:0]        i_rx_byte       = '0;
    logic              o_out_valid;
    logic              i_out_ready     = 1'b0;
    logic [CH_W-1:0]   o_channel_index;
    logic [15:0]       o_channel_value;
    logic              o_last_channel;

    // Requests waiting for the driver, and channel values still owed.
    link_event_t   pending_events[$];
    channel_word_t expected_channels[$];

    int items_queued = 0;
    int items_taken  = 0;
    int failures     = 0;
    int cycle_count  = 0;
    int send_pause   = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_armed   = 1'b0;
    bit hold_done    = 1'b0;
    bit calm         = 1'b0;

    // Register copies and parser state for the prediction.
    logic [7:0]       hdr_len_cfg = 8'd32;
    logic [7:0]       hdr_cmd_cfg = 8'd64;
    logic [7:0]       gap_ms_cfg  = 8'd10;
    logic [7:0]       frame_mem[FRAME_BYTES];
    logic [POS_W-1:0] frame_pos   = '0;
    logic [7:0]       idle_count  = '0;

    // Scratch frame assembled by the stimulus code.
    logic [7:0] frame_buf[FRAME_BYTES];

    rc_servo_frame_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

    always #10 i_clk = ~i_clk;

    // Advance the parser copy by one request and queue any channel values.
    function automatic void parse_link_event(input t_cmd cmd, input logic [7:0] b);
        logic [15:0]   csum;
        channel_word_t word;
        int            k;
        if (cmd == CMD_TICK) begin
            if (idle_count != IDLE_MAX) begin
                idle_count++;
            end
            return;
        end
        if (idle_count > gap_ms_cfg) begin
            frame_pos = '0;
        end
        idle_count = '0;
        if (frame_pos == 0 && b != hdr_len_cfg) begin
            return;
        end
        if (frame_pos == 1 && b != hdr_cmd_cfg) begin
            frame_pos = '0;
            return;
        end
        frame_mem[frame_pos] = b;
        frame_pos++;
        if (frame_pos != 0) begin
            return;
        end
        // Whole frame in: check the sum before releasing the channels.
        csum = CSUM_SEED;
        for (k = 0; k < CSUM_SPAN; k++) begin
            csum = csum - frame_mem[k];
        end
        if (csum != {frame_mem[CSUM_SPAN+1], frame_mem[CSUM_SPAN]}) begin
            return;
        end
        for (k = 0; k < CHANNELS; k++) begin
            word.index = k[CH_W-1:0];
            word.value = {frame_mem[3+2*k], frame_mem[2+2*k]};
            word.last  = (k == CHANNELS - 1);
            expected_channels.push_back(word);
        end
    endfunction

    // Input driver: predicts each request as it is taken, then loads the next.
    always @(posedge i_clk) begin
        link_event_t nxt;
        logic        load;
        load = 1'b0;
        nxt  = '0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                parse_link_event(t_cmd'(i_command), i_rx_byte);
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_pause > 0) begin
                    send_pause--;
                end else if (pending_events.size() > 0) begin
                    nxt  = pending_events.pop_front();
                    load = 1'b1;
                    if (!calm && $urandom_range(3) == 0) begin
                        send_pause = $urandom_range(1, 14);
                    end
                end
                i_in_valid <= load;
                if (load) begin
                    i_command <= nxt.cmd;
                    i_rx_byte <= nxt.data;
                end
            end
        end
    end

    // Output monitor: checks each channel value and paces the ready line.
    always @(posedge i_clk) begin
        channel_word_t want;
        logic          rdy;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_channels.size() == 0) begin
                    $error("unexpected channel result: index %0d value %h",
                           o_channel_index, o_channel_value);
                    failures++;
                end else begin
                    want = expected_channels.pop_front();
                    if (o_channel_index !== want.index) begin
                        $error("channel_index mismatch: expected %0d, got %0d",
                               want.index, o_channel_index);
                        failures++;
                    end
                    if (o_channel_value !== want.value) begin
                        $error("channel_value mismatch: expected %h, got %h",
                               want.value, o_channel_value);
                        failures++;
                    end
                    if (o_last_channel !== want.last) begin
                        $error("last_channel mismatch: expected %0b, got %0b",
                               want.last, o_last_channel);
                        failures++;
                    end
                end
            end
            // A single long hold-off lets the banks fill and the input stall.
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (!calm && $urandom_range(5) == 0) begin
                    stall_left = $urandom_range(1, 14);
                    rdy        = 1'b0;
                end
            end
            i_out_ready <= rdy;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void offer(input t_cmd cmd, input logic [7:0] b);
        link_event_t ev;
        ev.cmd  = cmd;
        ev.data = b;
        pending_events.push_back(ev);
        items_queued++;
    endfunction

    function automatic void offer_ticks(input int n);
        repeat (n) offer(CMD_TICK, 8'($urandom_range(255)));
    endfunction

    // Fill frame_buf with a frame; alternate gives 0x0000/0xFFFF channels.
    function automatic void build_frame(input logic [7:0] len_b, input logic [7:0] cmd_b,
                                        input bit alternate, input bit corrupt);
        logic [15:0] sum;
        logic [15:0] val;
        int          k;
        frame_buf[0] = len_b;
        frame_buf[1] = cmd_b;
        for (k = 0; k < CHANNELS; k++) begin
            if (alternate) begin
                val = k[0] ? 16'hFFFF : 16'h0000;
            end else begin
                case ($urandom_range(7))
                    0:       val = 16'h0000;
                    1:       val = 16'hFFFF;
                    default: val = 16'($urandom_range(16'hFFFF));
                endcase
            end
            frame_buf[2+2*k] = val[7:0];
            frame_buf[3+2*k] = val[15:8];
        end
        sum = CSUM_SEED;
        for (k = 0; k < CSUM_SPAN; k++) begin
            sum = sum - frame_buf[k];
        end
        if (corrupt) begin
            sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        end
        frame_buf[CSUM_SPAN]   = sum[7:0];
        frame_buf[CSUM_SPAN+1] = sum[15:8];
    endfunction

    // Offer a slice of frame_buf, with the odd short run of ticks inside the
    // gap timeout so the frame survives.
    function automatic void offer_bytes(input int first, input int last);
        int i;
        int cap;
        cap = (gap_ms_cfg < 3) ? gap_ms_cfg : 3;
        for (i = first; i <= last; i++) begin
            offer(CMD_BYTE, frame_buf[i]);
            if (cap > 0 && i < last && $urandom_range(5) == 0) begin
                offer_ticks($urandom_range(1, cap));
            end
        end
    endfunction

    // Mostly good frames with random content, the rest broken or noise.
    function automatic void add_random_traffic(input int budget);
        int stop_at;
        int cut;
        stop_at = items_queued + budget;
        while (items_queued < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    build_frame(hdr_len_cfg, hdr_cmd_cfg, 1'b0, 1'b0);
                    offer_bytes(0, FRAME_BYTES - 1);
                end
                6: begin
                    build_frame(hdr_len_cfg, hdr_cmd_cfg, 1'b0, 1'b1);
                    offer_bytes(0, FRAME_BYTES - 1);
                end
                7: begin
                    // Cut short, then a gap long enough to restart.
                    build_frame(hdr_len_cfg, hdr_cmd_cfg, 1'b0, 1'b0);
                    cut = $urandom_range(1, FRAME_BYTES - 2);
                    offer_bytes(0, cut);
                    if (gap_ms_cfg < 16) begin
                        offer_ticks(gap_ms_cfg + 1 + $urandom_range(2));
                    end
                end
                default: begin
                    if ($urandom_range(2) == 0) begin
                        offer(CMD_BYTE, hdr_len_cfg);
                    end
                    repeat ($urandom_range(1, 5)) begin
                        case ($urandom_range(3))
                            0:       offer(CMD_TICK, 8'($urandom_range(255)));
                            1:       offer(CMD_BYTE, hdr_cmd_cfg);
                            default: offer(CMD_BYTE, 8'($urandom_range(255)));
                        endcase
                    end
                end
            endcase
        end
    endfunction

    // Register write followed by a read back of the same register.
    task automatic set_parser_reg(input t_reg_idx idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LEN: hdr_len_cfg = val;
            REG_CMD: hdr_cmd_cfg = val;
            REG_GAP: gap_ms_cfg  = val;
            default: ;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {24'h0, val}) begin
            $error("prdata mismatch at register %0d: expected %h, got %h",
                   idx, {24'h0, val}, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (items_taken != items_queued || expected_channels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus sequence, one phase per register setting.
    initial begin
        int guard;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: header errors first.
        offer(CMD_BYTE, 8'h00);
        offer(CMD_BYTE, 8'hFF);
        offer(CMD_BYTE, hdr_cmd_cfg);
        offer(CMD_BYTE, hdr_len_cfg);
        offer(CMD_BYTE, hdr_len_cfg);
        offer(CMD_BYTE, hdr_cmd_cfg);
        offer_ticks(3);
        // One millisecond past the timeout restarts a partial frame.
        build_frame(hdr_len_cfg, hdr_cmd_cfg, 1'b0, 1'b0);
        offer_bytes(0, 5);
        offer_ticks(gap_ms_cfg + 1);
        // The long receiver hold-off starts while the next frames go in.
        hold_armed = 1'b1;
        // Idle exactly at the timeout keeps the frame going.
        offer_bytes(0, 5);
        offer_ticks(gap_ms_cfg);
        offer_bytes(6, FRAME_BYTES - 1);
        build_frame(hdr_len_cfg, hdr_cmd_cfg, 1'b1, 1'b0);
        offer_bytes(0, FRAME_BYTES - 1);
        add_random_traffic(30);
        wait_until_drained();

        // Final stretch with no idling: extreme header values and the top
        // timeout, where a saturated idle count never restarts the frame.
        set_parser_reg(REG_LEN, 8'hFF);
        set_parser_reg(REG_CMD, 8'h00);
        set_parser_reg(REG_GAP, 8'd255);
        calm = 1'b1;
        build_frame(hdr_len_cfg, hdr_cmd_cfg, 1'b0, 1'b0);
        offer_bytes(0, 4);
        offer_ticks(SAT_TICKS);
        offer_bytes(5, FRAME_BYTES - 1);

        while (items_taken != items_queued) begin
            @(posedge i_clk);
        end
        guard = 0;
        while (expected_channels.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_channels.size() != 0) begin
            $error("%0d channel results never arrived", expected_channels.size());
            failures++;
        end

        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> rc_servo_frame_parser_core.f
+incdir+design
design/rcsfp_pkg.sv
design/rcsfp_frame_store.sv
design/rcsfp_front.sv
design/rcsfp_frame_queue.sv
design/rcsfp_back.sv
design/rc_servo_frame_parser_core.sv
tb/rc_servo_frame_parser_core_tb.sv
